// File: src/cpm_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the current pulse monitor.
package cpm_pkg;

	localparam int unsigned CurWidth  = 16;
	localparam int unsigned TimeWidth = 32;
	localparam int unsigned CfgIdxWidth = 3;

	typedef logic [CurWidth-1:0]    cur_t;
	typedef logic [TimeWidth-1:0]   tstamp_t;
	typedef logic [1:0]             zone_t;
	typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

	localparam zone_t ZONE_OK      = 2'd0;
	localparam zone_t ZONE_WARN    = 2'd1;
	localparam zone_t ZONE_INVALID = 2'd2;
	localparam zone_t ZONE_NONE    = 2'd3;

	localparam cfg_idx_t REG_NOMINAL     = 3'd0;
	localparam cfg_idx_t REG_MAX_GAP     = 3'd1;
	localparam cfg_idx_t REG_RAMP_START  = 3'd2;
	localparam cfg_idx_t REG_RAMP_WINDOW = 3'd3;
	localparam cfg_idx_t REG_RAMP_TARGET = 3'd4;
	localparam cfg_idx_t REG_WARN_LEVEL  = 3'd5;
	localparam cfg_idx_t REG_FAIL_LEVEL  = 3'd6;
	localparam cfg_idx_t REG_MAX_INVALID = 3'd7;

	typedef struct packed {
		logic    started;
		logic    reached;
		logic    failed;
		cur_t    peak;
		tstamp_t deadline;
	} ramp_status_t;

	typedef struct packed {
		zone_t   zone;
		tstamp_t ok_time;
		tstamp_t warn_time;
		tstamp_t invalid_time;
		logic    timeout;
	} zone_status_t;

endpackage

// File: src/current_pulse_monitor_unit.sv
`timescale 1ns / 1ps
// Current pulse monitor: top level with config registers, input and result registers.
// Flow: an accepted sample is registered in the input register (stage 1) and moves on to
// the result register (stage 2), which raises out_valid, once that register is free.
// Throughput: one sample per cycle unless the output stalls; glitch, ramp and zone
// update combinationally between the registers; the input stalls only while both are full.
// Reset: arst_n clears monitor state, config (invalid-time limit 65535) and valid flags.
module current_pulse_monitor_unit import cpm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_we,
	input  cfg_idx_t          cfg_index,
	input  logic [15:0]       cfg_data,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic [15:0]       current_ma,
	input  logic [31:0]       time_ms,

	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       effective_ma,
	output logic [1:0]        zone,
	output logic [31:0]       ok_time_ms,
	output logic [31:0]       warn_time_ms,
	output logic [31:0]       invalid_time_ms,
	output logic [15:0]       peak_ma,
	output logic              ramp_started,
	output logic              ramp_reached,
	output logic              ramp_failed,
	output logic              invalid_timeout
);

	// Configuration registers
	cur_t nominal_q;
	cur_t max_gap_q;
	cur_t ramp_start_q;
	cur_t ramp_window_q;
	cur_t ramp_target_q;
	cur_t warn_level_q;
	cur_t fail_level_q;
	cur_t max_invalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q     <= '0;
			max_gap_q     <= '0;
			ramp_start_q  <= '0;
			ramp_window_q <= '0;
			ramp_target_q <= '0;
			warn_level_q  <= '0;
			fail_level_q  <= '0;
			max_invalid_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NOMINAL:     nominal_q     <= cfg_data;
				REG_MAX_GAP:     max_gap_q     <= cfg_data;
				REG_RAMP_START:  ramp_start_q  <= cfg_data;
				REG_RAMP_WINDOW: ramp_window_q <= cfg_data;
				REG_RAMP_TARGET: ramp_target_q <= cfg_data;
				REG_WARN_LEVEL:  warn_level_q  <= cfg_data;
				REG_FAIL_LEVEL:  fail_level_q  <= cfg_data;
				REG_MAX_INVALID: max_invalid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register (stage 1) and flow control.
	// Stage 1 advances whenever the result register is empty or being taken;
	// the input stalls only while stage 1 holds a transaction that cannot advance.
	logic    valid_s1;
	cur_t    current_s1;
	tstamp_t time_s1;
	logic    valid_s2;
	logic    out_free;
	logic    advance_s1;
	logic    in_take;

	assign out_free   = !valid_s2 || !out_stall;
	assign advance_s1 = valid_s1 && out_free;
	assign in_stall   = valid_s1 && !out_free;
	assign in_take    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			current_s1 <= current_ma;
			time_s1    <= time_ms;
		end
	end

	// Per-sample update: glitch hold, then ramp, then zone accounting
	cur_t         eff;
	ramp_status_t ramp_st;
	zone_status_t zone_st;

	cpm_glitch u_glitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance_s1),
		.cur     (current_s1),
		.t       (time_s1),
		.nominal (nominal_q),
		.max_gap (max_gap_q),
		.eff     (eff)
	);

	cpm_ramp u_ramp (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance_s1),
		.cur         (current_s1),
		.t           (time_s1),
		.start_level (ramp_start_q),
		.window      (ramp_window_q),
		.target      (ramp_target_q),
		.status      (ramp_st)
	);

	cpm_zone u_zone (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance_s1),
		.eff         (eff),
		.t           (time_s1),
		.deadline    (ramp_st.deadline),
		.warn_level  (warn_level_q),
		.fail_level  (fail_level_q),
		.max_invalid (max_invalid_q),
		.status      (zone_st)
	);

	// Result register (stage 2): hold while stalled, drop valid once taken
	cur_t         eff_s2;
	ramp_status_t ramp_s2;
	zone_status_t zone_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			eff_s2  <= eff;
			ramp_s2 <= ramp_st;
			zone_s2 <= zone_st;
		end
	end

	assign out_valid       = valid_s2;
	assign effective_ma    = eff_s2;
	assign zone            = zone_s2.zone;
	assign ok_time_ms      = zone_s2.ok_time;
	assign warn_time_ms    = zone_s2.warn_time;
	assign invalid_time_ms = zone_s2.invalid_time;
	assign invalid_timeout = zone_s2.timeout;
	assign peak_ma         = ramp_s2.peak;
	assign ramp_started    = ramp_s2.started;
	assign ramp_reached    = ramp_s2.reached;
	assign ramp_failed     = ramp_s2.failed;

	// Checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled without a transaction blocked in stage 1");

	a_ramp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(ramp_failed && ramp_reached))
		else $error("ramp reported both reached and failed");

	a_peak_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (peak_ma != '0)) |-> ramp_started)
		else $error("window peak recorded before ramp start");

endmodule

// File: src/cpm_glitch.sv
`timescale 1ns / 1ps
// Glitch filter: holds the last good current through a short dip below nominal.
module cpm_glitch import cpm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  cur_t    cur,
	input  tstamp_t t,
	input  cur_t    nominal,
	input  cur_t    max_gap,
	output cur_t    eff
);

	tstamp_t last_time_q;
	cur_t    last_current_q;
	logic    dip_active_q;
	tstamp_t dip_start_q;
	cur_t    held_current_q;

	logic    below;
	logic    dip_new;
	tstamp_t start_n;
	cur_t    held_n;
	tstamp_t dip_len;

	always_comb begin
		below   = cur < nominal;
		dip_new = below && !dip_active_q;
		start_n = dip_new ? last_time_q : dip_start_q;
		held_n  = dip_new ? last_current_q : held_current_q;
		dip_len = t - start_n;
		eff     = (below && (dip_len < {{(TimeWidth-CurWidth){1'b0}}, max_gap})) ? held_n : cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q    <= '0;
			last_current_q <= '0;
			dip_active_q   <= 1'b0;
			dip_start_q    <= '0;
			held_current_q <= '0;
		end else if (step) begin
			last_time_q    <= t;
			last_current_q <= cur;
			dip_active_q   <= below;
			dip_start_q    <= start_n;
			held_current_q <= held_n;
		end
	end

endmodule

// File: src/cpm_ramp.sv
`timescale 1ns / 1ps
// Ramp detector: start, window peak, target reached and deadline.
module cpm_ramp import cpm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  cur_t         cur,
	input  tstamp_t      t,
	input  cur_t         start_level,
	input  cur_t         window,
	input  cur_t         target,
	output ramp_status_t status
);

	logic    on_q;
	tstamp_t deadline_q;
	logic    hit_q;
	logic    done_q;
	cur_t    peak_q;

	logic    start_now;
	logic    on_n;
	tstamp_t deadline_n;
	logic    active;
	cur_t    peak_n;
	logic    hit_n;
	logic    done_n;

	always_comb begin
		start_now  = !on_q && (cur > start_level);
		on_n       = on_q || start_now;
		deadline_n = start_now ? (t + {{(TimeWidth-CurWidth){1'b0}}, window}) : deadline_q;
		active     = on_n && !done_q;
		peak_n     = (active && (t <= deadline_n) && (cur > peak_q)) ? cur : peak_q;
		hit_n      = hit_q || (active && (cur >= target));
		done_n     = done_q || (active && (t >= deadline_n));

		status.started  = on_n;
		status.reached  = hit_n;
		status.failed   = on_n && done_n && !hit_n;
		status.peak     = peak_n;
		status.deadline = deadline_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q       <= 1'b0;
			deadline_q <= '1;
			hit_q      <= 1'b0;
			done_q     <= 1'b0;
			peak_q     <= '0;
		end else if (step) begin
			on_q       <= on_n;
			deadline_q <= deadline_n;
			hit_q      <= hit_n;
			done_q     <= done_n;
			peak_q     <= peak_n;
		end
	end

endmodule

// File: src/cpm_zone.sv
`timescale 1ns / 1ps
// Zone classifier with saturating time accumulators and invalid-time timeout.
module cpm_zone import cpm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  cur_t         eff,
	input  tstamp_t      t,
	input  tstamp_t      deadline,
	input  cur_t         warn_level,
	input  cur_t         fail_level,
	input  cur_t         max_invalid,
	output zone_status_t status
);

	logic    started_q;
	tstamp_t prev_time_q;
	tstamp_t ok_q;
	tstamp_t warn_q;
	tstamp_t invalid_q;
	logic    timeout_q;

	logic              classify;
	tstamp_t           prev;
	tstamp_t           dt;
	zone_t             zone;
	tstamp_t           acc_sel;
	logic [TimeWidth:0] sum;
	tstamp_t           acc_new;
	tstamp_t           ok_n;
	tstamp_t           warn_n;
	tstamp_t           invalid_n;
	logic              timeout_n;

	always_comb begin
		classify = t >= deadline;
		prev     = started_q ? prev_time_q : t;
		dt       = t - prev;

		if (!classify) begin
			zone = ZONE_NONE;
		end else if ((fail_level != '0) && (eff < fail_level)) begin
			zone = ZONE_INVALID;
		end else if ((warn_level != '0) && (eff < warn_level)) begin
			zone = ZONE_WARN;
		end else begin
			zone = ZONE_OK;
		end

		case (zone)
			ZONE_INVALID: acc_sel = invalid_q;
			ZONE_WARN:    acc_sel = warn_q;
			default:      acc_sel = ok_q;
		endcase
		sum     = {1'b0, acc_sel} + {1'b0, dt};
		acc_new = sum[TimeWidth] ? '1 : sum[TimeWidth-1:0];

		// a zero step leaves acc_new equal to the accumulator, so no extra test
		ok_n      = (zone == ZONE_OK)      ? acc_new : ok_q;
		warn_n    = (zone == ZONE_WARN)    ? acc_new : warn_q;
		invalid_n = (zone == ZONE_INVALID) ? acc_new : invalid_q;
		timeout_n = timeout_q ||
			(invalid_n > {{(TimeWidth-CurWidth){1'b0}}, max_invalid});

		status.zone         = zone;
		status.ok_time      = ok_n;
		status.warn_time    = warn_n;
		status.invalid_time = invalid_n;
		status.timeout      = timeout_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			prev_time_q <= '0;
			ok_q        <= '0;
			warn_q      <= '0;
			invalid_q   <= '0;
			timeout_q   <= 1'b0;
		end else if (step) begin
			if (classify) begin
				started_q   <= 1'b1;
				prev_time_q <= t;
			end
			ok_q      <= ok_n;
			warn_q    <= warn_n;
			invalid_q <= invalid_n;
			timeout_q <= timeout_n;
		end
	end

endmodule
